// ----- hdl/ctl_pkg.sv -----
// ----------------------------------------------------------------------------
// ctl_pkg: shared types and constants for the closed tour length block
// Widths of coordinates, squared distance, root and accumulator.
// ----------------------------------------------------------------------------
package ctl_pkg;
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int MAX_NODES  = 4096;
   localparam int LEN_BITS   = 45;
   localparam int CNT_BITS   = 13;
   // squared distance, then scaled by 4^FRAC_BITS; radicand padded to even width
   localparam int SQ_BITS    = 2 * COORD_BITS + 1;
   localparam int ROOT_BITS  = (SQ_BITS + 2 * FRAC_BITS + 1) / 2;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int NCELLS     = ROOT_BITS;

   // data handed from one root cell to the next
   typedef struct packed {
      logic [RAD_BITS-1:0]  rad;
      logic [ROOT_BITS-1:0] root;
      logic [REM_BITS-1:0]  rem;
   } root_bus_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_EDGE, ST_CLOSE, ST_OUT
   } state_type;
endpackage

// ----- hdl/closed_tour_length.sv -----
// ----------------------------------------------------------------------------
// closed_tour_length: Euclidean length of a closed tour
// Streams tour nodes in, gives total length and node count per tour.
// ----------------------------------------------------------------------------
// Usage:
//  req_ carries one node (coord_x, coord_y, last_node) per beat.
//  rsp_ gives one beat per tour on its last node: total_length (16 fraction
//  bits, saturating) and node_count (saturating at MAX_NODES).
//  The first node of a tour opens it (a one-node tour goes straight to the
//  result). Each later node registers the squared distance, passes it through
//  the row of square root cells (one cell per cycle) and then adds the edge.
//  A last node needs a second pass for the closing edge; the result beat
//  comes up after that pass.
//  One node is in work at a time. req_ready is low while an edge is in the
//  root row or a result waits; a stalled receiver holds the result and the
//  block takes nothing more until it is taken.
//  Reset clears the tour state and drops all valid flags.
// ----------------------------------------------------------------------------
module closed_tour_length (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ctl_pkg::COORD_BITS-1:0]    req_coord_x,
   input  logic [ctl_pkg::COORD_BITS-1:0]    req_coord_y,
   input  logic                              req_last_node,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ctl_pkg::LEN_BITS-1:0]      rsp_total_length,
   output logic [ctl_pkg::CNT_BITS-1:0]      rsp_node_count
);
   localparam int CW = ctl_pkg::COORD_BITS;
   localparam logic [5:0] WAIT = 6'(ctl_pkg::NCELLS);
   localparam logic [ctl_pkg::LEN_BITS-1:0] LEN_MAX = '1;

   ctl_pkg::state_type state_ff, state_in;
   logic            in_tour_ff, in_tour_in;
   logic [CW-1:0]   first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [CW-1:0]   prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic            last_ff, last_in;
   logic [ctl_pkg::LEN_BITS-1:0] len_ff, len_in;
   logic [ctl_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [5:0]      wait_ff, wait_in;
   logic [ctl_pkg::SQ_BITS-1:0]  sq_ff, sq_in;
   logic [ctl_pkg::ROOT_BITS-1:0] root;
   logic [ctl_pkg::LEN_BITS:0]   sum;
   logic            accept;

   ctl_root_chain u_chain (
      .clock (clock),
      .enable(1'b1),
      .sq    (sq_ff),
      .root  (root)
   );

   function automatic logic [ctl_pkg::SQ_BITS-1:0] sqdist(
      input logic [CW-1:0] ax, ay, bx, by);
      logic [CW-1:0] ex, ey;
      ex = (ax >= bx) ? ax - bx : bx - ax;
      ey = (ay >= by) ? ay - by : by - ay;
      return ctl_pkg::SQ_BITS'(ex) * ctl_pkg::SQ_BITS'(ex) +
             ctl_pkg::SQ_BITS'(ey) * ctl_pkg::SQ_BITS'(ey);
   endfunction

   assign accept = req_valid && req_ready;
   assign sum    = {1'b0, len_ff} + (ctl_pkg::LEN_BITS+1)'(root);

   always_comb begin
      state_in   = state_ff;
      in_tour_in = in_tour_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      last_in    = last_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff;
      wait_in    = wait_ff;
      sq_in      = sq_ff;
      req_ready  = (state_ff == ctl_pkg::ST_IDLE);
      rsp_valid  = (state_ff == ctl_pkg::ST_OUT);
      unique case (state_ff)
         ctl_pkg::ST_IDLE: begin
            if (accept) begin
               prev_x_in = req_coord_x;
               prev_y_in = req_coord_y;
               last_in   = req_last_node;
               wait_in   = WAIT;
               if (!in_tour_ff) begin
                  first_x_in = req_coord_x;
                  first_y_in = req_coord_y;
                  len_in     = '0;
                  cnt_in     = ctl_pkg::CNT_BITS'(1);
                  in_tour_in = 1'b1;
                  if (req_last_node) state_in = ctl_pkg::ST_OUT;
               end else begin
                  sq_in = sqdist(prev_x_ff, prev_y_ff, req_coord_x, req_coord_y);
                  if (cnt_ff < ctl_pkg::CNT_BITS'(ctl_pkg::MAX_NODES))
                     cnt_in = cnt_ff + 1'b1;
                  state_in = ctl_pkg::ST_EDGE;
               end
            end
         end
         ctl_pkg::ST_EDGE: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 1'b1;
            end else begin
               len_in = sum[ctl_pkg::LEN_BITS] ? LEN_MAX : sum[ctl_pkg::LEN_BITS-1:0];
               if (last_ff) begin
                  sq_in    = sqdist(prev_x_ff, prev_y_ff, first_x_ff, first_y_ff);
                  wait_in  = WAIT;
                  state_in = ctl_pkg::ST_CLOSE;
               end else begin
                  state_in = ctl_pkg::ST_IDLE;
               end
            end
         end
         ctl_pkg::ST_CLOSE: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 1'b1;
            end else begin
               len_in = sum[ctl_pkg::LEN_BITS] ? LEN_MAX : sum[ctl_pkg::LEN_BITS-1:0];
               state_in = ctl_pkg::ST_OUT;
            end
         end
         ctl_pkg::ST_OUT: begin
            if (rsp_ready) begin
               in_tour_in = 1'b0;
               state_in   = ctl_pkg::ST_IDLE;
            end
         end
         default: state_in = ctl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ctl_pkg::ST_IDLE;
         in_tour_ff <= 1'b0;
         wait_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         in_tour_ff <= in_tour_in;
         wait_ff    <= wait_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      last_ff    <= last_in;
      len_ff     <= len_in;
      cnt_ff     <= cnt_in;
      sq_ff      <= sq_in;
   end

   assign rsp_total_length = len_ff;
   assign rsp_node_count   = cnt_ff;

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while result pending");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_node_count != '0 &&
                     rsp_node_count <= ctl_pkg::CNT_BITS'(ctl_pkg::MAX_NODES)))
      else $error("node count out of range");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_length))
      else $error("result changed while stalled");
endmodule

// ----- hdl/ctl_root_cell.sv -----
// ----------------------------------------------------------------------------
// ctl_root_cell: one digit of a restoring square root
// Takes two radicand bits, forms one root bit, passes the rest on.
// ----------------------------------------------------------------------------
module ctl_root_cell (
   input  logic                  clock,
   input  logic                  enable,
   input  ctl_pkg::root_bus_type bus_in,
   output ctl_pkg::root_bus_type bus_out
);
   ctl_pkg::root_bus_type bus_ff, bus_in_w;
   logic [ctl_pkg::REM_BITS-1:0] part, trial;

   always_comb begin
      part  = {bus_in.rem[ctl_pkg::REM_BITS-3:0],
               bus_in.rad[ctl_pkg::RAD_BITS-1 -: 2]};
      trial = {bus_in.root, 2'b01};
      bus_in_w.rad = {bus_in.rad[ctl_pkg::RAD_BITS-3:0], 2'b00};
      if (part >= trial) begin
         bus_in_w.rem  = part - trial;
         bus_in_w.root = {bus_in.root[ctl_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
         bus_in_w.rem  = part;
         bus_in_w.root = {bus_in.root[ctl_pkg::ROOT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) bus_ff <= bus_in_w;
   end

   assign bus_out = bus_ff;
endmodule

// ----- hdl/ctl_root_chain.sv -----
// ----------------------------------------------------------------------------
// ctl_root_chain: row of root cells computing sqrt(sq) with fraction bits
// Every cell advances each enabled cycle; the result leaves the last cell.
// ----------------------------------------------------------------------------
module ctl_root_chain (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [ctl_pkg::SQ_BITS-1:0]   sq,
   output logic [ctl_pkg::ROOT_BITS-1:0] root
);
   ctl_pkg::root_bus_type link [ctl_pkg::NCELLS+1];

   always_comb begin
      link[0].rad  = ctl_pkg::RAD_BITS'({sq, {(2*ctl_pkg::FRAC_BITS){1'b0}}});
      link[0].root = '0;
      link[0].rem  = '0;
   end

   for (genvar i = 0; i < ctl_pkg::NCELLS; i++) begin : g_cell
      ctl_root_cell u_cell (
         .clock (clock),
         .enable(enable),
         .bus_in(link[i]),
         .bus_out(link[i+1])
      );
   end

   assign root = link[ctl_pkg::NCELLS].root;
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: closed tour length testbench
// Streams tours through the block, predicts each tour's total and node count
// and compares every result beat against the predicted queue.
// ----------------------------------------------------------------------------
module tb_top;
   localparam int LMAX = (1 << 16) - 1;

   typedef struct {
      logic [ctl_pkg::COORD_BITS-1:0] x;
      logic [ctl_pkg::COORD_BITS-1:0] y;
      logic                           last;
      logic                           has_exp;
      logic [ctl_pkg::LEN_BITS-1:0]   exp_len;
      logic [ctl_pkg::CNT_BITS-1:0]   exp_cnt;
   } node_row_type;

   typedef struct {
      logic [ctl_pkg::LEN_BITS-1:0] len;
      logic [ctl_pkg::CNT_BITS-1:0] cnt;
   } tour_sum_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [ctl_pkg::COORD_BITS-1:0] req_coord_x = '0;
   logic [ctl_pkg::COORD_BITS-1:0] req_coord_y = '0;
   logic req_last_node = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [ctl_pkg::LEN_BITS-1:0] rsp_total_length;
   logic [ctl_pkg::CNT_BITS-1:0] rsp_node_count;

   closed_tour_length uut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic                           tour_open = 0;
   logic [ctl_pkg::COORD_BITS-1:0] start_x, start_y, last_x, last_y;
   logic [63:0]                    run_len;
   int                             run_cnt;
   tour_sum_type                   tour_q[$];
   node_row_type                   dir_tab[$];
   int                             errors = 0;
   int                             send_idle = 0;
   int                             recv_stall = 0;

   // truncated distance with FRAC_BITS fraction bits (bit-serial root)
   function automatic logic [63:0] edge_len(logic [15:0] ax, logic [15:0] ay,
                                            logic [15:0] bx, logic [15:0] by);
      logic [63:0] dx, dy;
      logic [127:0] rad, rem, root, trial;
      dx = (ax >= bx) ? ax - bx : bx - ax;
      dy = (ay >= by) ? ay - by : by - ay;
      rad = (dx * dx + dy * dy) << (2 * ctl_pkg::FRAC_BITS);
      rem = 0;
      root = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = (rem << 2) | ((rad >> (2 * i)) & 3);
         trial = (root << 2) | 1;
         root = root << 1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = root | 1;
         end
      end
      return root[63:0];
   endfunction

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > (64'd1 << ctl_pkg::LEN_BITS) - 1) ?
             (64'd1 << ctl_pkg::LEN_BITS) - 1 : s;
   endfunction

   task automatic predict_node(logic [15:0] x, logic [15:0] y, logic last);
      tour_sum_type t;
      if (!tour_open) begin
         start_x = x;
         start_y = y;
         run_len = 0;
         run_cnt = 1;
         tour_open = 1;
      end else begin
         run_len = sat_add(run_len, edge_len(last_x, last_y, x, y));
         if (run_cnt < ctl_pkg::MAX_NODES) run_cnt++;
      end
      last_x = x;
      last_y = y;
      if (last) begin
         run_len = sat_add(run_len, edge_len(x, y, start_x, start_y));
         t.len = run_len[ctl_pkg::LEN_BITS-1:0];
         t.cnt = run_cnt[ctl_pkg::CNT_BITS-1:0];
         tour_q.push_back(t);
         tour_open = 0;
      end
   endtask

   // valid drops only in an idle gap, so one edge never sees two drives
   task automatic send_node(logic [15:0] x, logic [15:0] y, logic last);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_last_node <= last;
      predict_node(x, y, last);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // result checking
   always @(posedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= recv_stall);
      if (!reset && rsp_valid && rsp_ready) begin
         if (tour_q.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            if (rsp_total_length !== tour_q[0].len) begin
               $error("total_length expected %0d got %0d", tour_q[0].len,
                      rsp_total_length);
               errors++;
            end
            if (rsp_node_count !== tour_q[0].cnt) begin
               $error("node_count expected %0d got %0d", tour_q[0].cnt,
                      rsp_node_count);
               errors++;
            end
            void'(tour_q.pop_front());
         end
      end
   end

   function automatic node_row_type mk(int x, int y, bit last, bit he = 0,
                                       longint el = 0, int ec = 0);
      node_row_type r;
      r.x = 16'(x);
      r.y = 16'(y);
      r.last = last;
      r.has_exp = he;
      r.exp_len = ctl_pkg::LEN_BITS'(el);
      r.exp_cnt = ctl_pkg::CNT_BITS'(ec);
      return r;
   endfunction

   function automatic logic [15:0] rnd_coord();
      case ($urandom_range(3))
         0: return 16'($urandom_range(15));
         1: return 16'(LMAX - int'($urandom_range(15)));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int len;
      // single node, zero edges, extremes, diagonal across the full square
      dir_tab.push_back(mk(0, 0, 1, 1, 0, 1));
      dir_tab.push_back(mk(LMAX, LMAX, 1, 1, 0, 1));
      dir_tab.push_back(mk(0, 0, 0));
      dir_tab.push_back(mk(LMAX, 0, 1, 1, 64'(2 * LMAX) << ctl_pkg::FRAC_BITS, 2));
      dir_tab.push_back(mk(0, LMAX, 0));
      dir_tab.push_back(mk(0, 0, 1, 1, 64'(2 * LMAX) << ctl_pkg::FRAC_BITS, 2));
      dir_tab.push_back(mk(3, 4, 0));
      dir_tab.push_back(mk(3, 4, 0));
      dir_tab.push_back(mk(0, 0, 1, 1, 64'd10 << ctl_pkg::FRAC_BITS, 3));
      dir_tab.push_back(mk(0, 0, 0));
      dir_tab.push_back(mk(LMAX, LMAX, 0));
      dir_tab.push_back(mk(0, LMAX, 0));
      dir_tab.push_back(mk(LMAX, 0, 1));
      dir_tab.push_back(mk(16'h5555, 16'haaaa, 0));
      dir_tab.push_back(mk(16'haaaa, 16'h5555, 1));
      dir_tab.push_back(mk(1, 0, 0));
      dir_tab.push_back(mk(0, 1, 1));

      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         send_node(dir_tab[i].x, dir_tab[i].y, dir_tab[i].last);
         // typed rows are checked against the typed values
         if (dir_tab[i].has_exp && dir_tab[i].last) begin
            tour_q[$].len = dir_tab[i].exp_len;
            tour_q[$].cnt = dir_tab[i].exp_cnt;
         end
      end

      for (int ph = 0; ph < 4; ph++) begin
         send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 63 : 10) : 0;
         recv_stall = (ph == 2) ? 63 : (ph == 3 ? 10 : 0);
         for (int n = 0; n < 370; n += len) begin
            len = ($urandom_range(7) == 0) ? 1 : int'($urandom_range(2, 12));
            for (int k = 0; k < len; k++)
               send_node(rnd_coord(), rnd_coord(), k == len - 1);
         end
      end
      req_valid <= 0;

      while (tour_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("closed_tour_length test passed");
      else
         $display("closed_tour_length test failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("closed_tour_length test failed");
      $finish;
   end
endmodule
